FILE: hw/rtl/csvfs_pkg.sv
// Shared types and constants for the comma-separated field splitter.
// Depends on nothing; every other file of the block but csvfs_if refers to it by scoped names.
`default_nettype none

package csvfs_pkg;

    // Character codes that steer the parse.
    localparam logic [7:0] QUOTE_CHAR = 8'h22;
    localparam logic [7:0] COMMA_CHAR = 8'h2C;

    // Most results that one text byte can cause.
    localparam int MAX_RESULTS = 3;

    // Configuration register map, by register index.
    localparam logic REG_COLLAPSE = 1'b0;
    localparam logic REG_ALLOW    = 1'b1;

    // Width of the configuration address.
    localparam int ADDR_W = 3;

    // Parser modes.
    typedef enum logic [2:0] {
        MODE_START  = 3'd0,
        MODE_PLAIN  = 3'd1,
        MODE_QUOTED = 3'd2,
        MODE_QSEEN  = 3'd3,
        MODE_SKIP   = 3'd4
    } mode_t;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    // Configuration as seen by the parser.
    typedef struct packed {
        logic collapse_quote_pairs;
        logic allow_inner_quotes;
    } cfg_t;

    // One result.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] field_byte;
    } result_t;

    // All results caused by one text byte.
    typedef struct packed {
        logic [1:0]                     count;
        logic                           line_end;
        result_t [MAX_RESULTS-1:0]      res;
    } bundle_t;

    // Hand-off from the parser to the result buffer.
    typedef struct packed {
        logic    load;
        bundle_t bundle;
    } xfer_t;

endpackage

`default_nettype wire

FILE: hw/rtl/csvfs_if.sv
// Valid/ready channel interfaces for the text input and the result output.
// Depends on nothing; used by the top level, the parser and the result buffer.
`default_nettype none

interface csvfs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       line_end;

    modport source (output valid, output text_byte, output line_end, input ready);
    modport sink   (input valid, input text_byte, input line_end, output ready);
endinterface

interface csvfs_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] field_byte;
    logic       line_done;
    logic       run_last;

    modport source (output valid, output kind, output field_byte, output line_done,
                    output run_last, input ready);
    modport sink   (input valid, input kind, input field_byte, input line_done,
                    input run_last, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/csvfs_regs.sv
// APB-style configuration registers of the field splitter.
// Depends on csvfs_pkg for the register map and the configuration struct.
`default_nettype none

module csvfs_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [csvfs_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    output csvfs_pkg::cfg_t                    cfg
);

    logic collapse_reg;
    logic allow_reg;
    logic wr_en;

    // Registers sit on 32-bit word addresses; the index is the word number.
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    // Register write at the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            collapse_reg <= 1'b1;
            allow_reg    <= 1'b1;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                csvfs_pkg::REG_COLLAPSE: collapse_reg <= pwdata[0];
                csvfs_pkg::REG_ALLOW:    allow_reg    <= pwdata[0];
                default:                 collapse_reg <= collapse_reg;
            endcase
        end
    end

    // Read back.
    always_comb
    begin
        unique case (paddr[2])
            csvfs_pkg::REG_COLLAPSE: prdata = {31'd0, collapse_reg};
            csvfs_pkg::REG_ALLOW:    prdata = {31'd0, allow_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    assign cfg.collapse_quote_pairs = collapse_reg;
    assign cfg.allow_inner_quotes   = allow_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/csvfs_parser.sv
// Input register, parse-mode register and the per-byte result decoder.
// Depends on csvfs_pkg and csvfs_if; feeds the result buffer through an xfer_t.
`default_nettype none

module csvfs_parser (
    input  wire logic             clk,
    input  wire logic             rst_n,
    csvfs_in_if.sink              in_ch,
    input  wire csvfs_pkg::cfg_t  cfg,
    input  wire logic             buf_free,
    output csvfs_pkg::xfer_t      xfer
);

    logic                  hold_valid_reg;
    logic [7:0]            text_byte_reg;
    logic                  line_end_reg;
    csvfs_pkg::mode_t      mode_reg;
    csvfs_pkg::mode_t      mode_next;
    csvfs_pkg::bundle_t    bundle;
    logic                  step;

    // The held byte moves on when its results fit, or when it has none.
    assign step         = hold_valid_reg && (buf_free || (bundle.count == 2'd0));
    assign in_ch.ready  = !hold_valid_reg || step;
    assign xfer.load    = step && (bundle.count != 2'd0);
    assign xfer.bundle  = bundle;

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            hold_valid_reg <= in_ch.valid;
        end
    end

    // Input payload.
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            text_byte_reg <= in_ch.text_byte;
            line_end_reg  <= in_ch.line_end;
        end
    end

    // Parse mode advances once per byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= csvfs_pkg::MODE_START;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
        end
    end

    // Decode one byte into its list of results and the next mode.
    always_comb
    begin
        logic [1:0]       n;
        logic             err;
        logic             is_q;
        logic             is_c;
        csvfs_pkg::mode_t m;

        n      = 2'd0;
        err    = 1'b0;
        m      = mode_reg;
        is_q   = (text_byte_reg == csvfs_pkg::QUOTE_CHAR);
        is_c   = (text_byte_reg == csvfs_pkg::COMMA_CHAR);
        bundle = '0;
        bundle.line_end = line_end_reg;

        unique case (mode_reg)
            csvfs_pkg::MODE_QSEEN:
            begin
                if (is_q && cfg.collapse_quote_pairs)
                begin
                    // Doubled quote stands for one quote.
                    bundle.res[n] = '{kind: csvfs_pkg::KIND_BYTE,
                                      field_byte: csvfs_pkg::QUOTE_CHAR};
                    n   = n + 2'd1;
                    m   = csvfs_pkg::MODE_QUOTED;
                    err = line_end_reg;
                end
                else if (is_c)
                begin
                    bundle.res[n] = '{kind: csvfs_pkg::KIND_END, field_byte: 8'd0};
                    n = n + 2'd1;
                    m = csvfs_pkg::MODE_START;
                    if (line_end_reg)
                    begin
                        bundle.res[n] = '{kind: csvfs_pkg::KIND_END, field_byte: 8'd0};
                        n = n + 2'd1;
                    end
                end
                else if (cfg.allow_inner_quotes)
                begin
                    // The pending quote was content after all.
                    bundle.res[n] = '{kind: csvfs_pkg::KIND_BYTE,
                                      field_byte: csvfs_pkg::QUOTE_CHAR};
                    n = n + 2'd1;
                    if (is_q)
                    begin
                        m = csvfs_pkg::MODE_QSEEN;
                        if (line_end_reg)
                        begin
                            bundle.res[n] = '{kind: csvfs_pkg::KIND_END, field_byte: 8'd0};
                            n = n + 2'd1;
                        end
                    end
                    else
                    begin
                        bundle.res[n] = '{kind: csvfs_pkg::KIND_BYTE,
                                          field_byte: text_byte_reg};
                        n   = n + 2'd1;
                        m   = csvfs_pkg::MODE_QUOTED;
                        err = line_end_reg;
                    end
                end
                else
                begin
                    // Strict mode: the field closed, and garbage follows.
                    bundle.res[n] = '{kind: csvfs_pkg::KIND_END, field_byte: 8'd0};
                    n   = n + 2'd1;
                    m   = csvfs_pkg::MODE_SKIP;
                    err = line_end_reg;
                end
            end
            csvfs_pkg::MODE_QUOTED:
            begin
                if (is_q)
                begin
                    m = csvfs_pkg::MODE_QSEEN;
                    if (line_end_reg)
                    begin
                        bundle.res[n] = '{kind: csvfs_pkg::KIND_END, field_byte: 8'd0};
                        n = n + 2'd1;
                    end
                end
                else
                begin
                    bundle.res[n] = '{kind: csvfs_pkg::KIND_BYTE, field_byte: text_byte_reg};
                    n   = n + 2'd1;
                    err = line_end_reg;
                end
            end
            csvfs_pkg::MODE_SKIP:
            begin
                err = line_end_reg;
            end
            default:
            begin
                // Field start, unquoted field, and any undefined code.
                if (mode_reg != csvfs_pkg::MODE_PLAIN && is_q)
                begin
                    m   = csvfs_pkg::MODE_QUOTED;
                    err = line_end_reg;
                end
                else if (is_c)
                begin
                    bundle.res[n] = '{kind: csvfs_pkg::KIND_END, field_byte: 8'd0};
                    n = n + 2'd1;
                    m = csvfs_pkg::MODE_START;
                    if (line_end_reg)
                    begin
                        bundle.res[n] = '{kind: csvfs_pkg::KIND_END, field_byte: 8'd0};
                        n = n + 2'd1;
                    end
                end
                else
                begin
                    bundle.res[n] = '{kind: csvfs_pkg::KIND_BYTE, field_byte: text_byte_reg};
                    n = n + 2'd1;
                    m = csvfs_pkg::MODE_PLAIN;
                    if (line_end_reg)
                    begin
                        bundle.res[n] = '{kind: csvfs_pkg::KIND_END, field_byte: 8'd0};
                        n = n + 2'd1;
                    end
                end
            end
        endcase

        // A format error is reported once, as the last result of the line.
        if (err)
        begin
            bundle.res[n] = '{kind: csvfs_pkg::KIND_ERROR, field_byte: 8'd0};
            n = n + 2'd1;
        end

        bundle.count = n;
        mode_next    = line_end_reg ? csvfs_pkg::MODE_START : m;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/csvfs_result_buf.sv
// Result register that holds the results of one byte and hands them out in order.
// Depends on csvfs_pkg and csvfs_if; loaded by the parser.
`default_nettype none

module csvfs_result_buf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire csvfs_pkg::xfer_t  xfer,
    output logic                   buf_free,
    csvfs_out_if.source            out_ch
);

    logic                 valid_reg;
    logic [1:0]           idx_reg;
    csvfs_pkg::bundle_t   bundle_reg;
    csvfs_pkg::result_t   cur;
    logic                 is_last;
    logic                 taken;

    assign cur      = bundle_reg.res[idx_reg];
    assign is_last  = (idx_reg == (bundle_reg.count - 2'd1));
    assign taken    = valid_reg && out_ch.ready;
    assign buf_free = !valid_reg || (taken && is_last);

    // Output port.
    assign out_ch.valid      = valid_reg;
    assign out_ch.kind       = cur.kind;
    assign out_ch.field_byte = cur.field_byte;
    assign out_ch.run_last   = is_last;
    assign out_ch.line_done  = is_last && bundle_reg.line_end;

    // Occupancy and read position.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else if (xfer.load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= 2'd0;
        end
        else if (taken)
        begin
            if (is_last)
            begin
                valid_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (xfer.load)
        begin
            bundle_reg <= xfer.bundle;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/csv_field_splitter.sv
// Top level of the comma-separated field splitter.
// Depends on csvfs_pkg, csvfs_if, csvfs_regs, csvfs_parser and csvfs_result_buf.
`default_nettype none

// The splitter takes one byte of a text line per transaction on in_ch, with
// line_end set on the line's last byte, and gives field bytes, field-end markers
// and format-error markers on out_ch, one result per transaction, with run_last on
// the last result of each byte and line_done on the last result of each line. A
// byte passes through an input register and then a result register, from which
// its results are offered on out_ch; it waits in the input register while the
// result register is still busy. The block takes one byte per cycle as long as
// each byte causes at most one result and out_ch is not stalled; a byte that
// causes two or three results occupies the result register until all of them
// are handed out, one result per cycle while out_ch is ready, and input is held
// meanwhile. Bytes that cause no result never wait on the output. The user must
// write the two configuration registers over the APB port, at byte addresses 0
// and 4, only while the block is idle; the block itself does not enforce this.
module csv_field_splitter (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    csvfs_in_if.sink                           in_ch,
    csvfs_out_if.source                        out_ch,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [csvfs_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready
);

    csvfs_pkg::cfg_t   cfg;
    csvfs_pkg::xfer_t  xfer;
    logic              buf_free;

    // Configuration registers.
    csvfs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Input register and decoder.
    csvfs_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .cfg      (cfg),
        .buf_free (buf_free),
        .xfer     (xfer)
    );

    // Result register and output sequencing.
    csvfs_result_buf u_result_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .xfer     (xfer),
        .buf_free (buf_free),
        .out_ch   (out_ch)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/csvfs_checker.sv
// Port-level checks of the field splitter's result stream, bound to the top level.
// Depends on csvfs_pkg for the result kind codes.
`default_nettype none

module csvfs_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [1:0] out_kind,
    input wire logic [7:0] out_field_byte,
    input wire logic       out_line_done,
    input wire logic       out_run_last
);

    // A stalled transaction stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn while stalled");

    // Only field bytes carry a nonzero byte value.
    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind != csvfs_pkg::KIND_BYTE |-> out_field_byte == 8'd0)
        else $error("marker result carries a byte value");

    // The end of a line is also the end of its byte's results.
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_line_done |-> out_run_last)
        else $error("line_done without run_last");

    // A format error is always the final result of its line.
    a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == csvfs_pkg::KIND_ERROR |-> out_line_done)
        else $error("format error not at line end");

    // Kind code three is never produced.
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_kind == csvfs_pkg::KIND_BYTE || out_kind == csvfs_pkg::KIND_END
                       || out_kind == csvfs_pkg::KIND_ERROR))
        else $error("undefined result kind");

endmodule

bind csv_field_splitter csvfs_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_kind       (out_ch.kind),
    .out_field_byte (out_ch.field_byte),
    .out_line_done  (out_ch.line_done),
    .out_run_last   (out_ch.run_last)
);

`default_nettype wire

FILE: verif/tb_top.sv
// Self-checking testbench for csv_field_splitter: directed lines, then random lines.
// Depends on csvfs_pkg and the csvfs_in_if / csvfs_out_if channel interfaces of the RTL.
module tb_top;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 61;

    // Register settings, packed as {collapse_quote_pairs, allow_inner_quotes}.
    localparam csvfs_pkg::cfg_t CFG_NONE  = 2'b00;
    localparam csvfs_pkg::cfg_t CFG_INNER = 2'b01;
    localparam csvfs_pkg::cfg_t CFG_PAIRS = 2'b10;
    localparam csvfs_pkg::cfg_t CFG_BOTH  = 2'b11;

    // One output transaction as the checker sees it.
    typedef struct packed {
        csvfs_pkg::kind_t kind;
        logic [7:0]       fbyte;
        logic             line_done;
        logic             run_last;
    } field_result_t;

    // One row of the directed table; kind is the last result of the byte when typed.
    typedef struct packed {
        logic [7:0]       text;
        logic             last;
        csvfs_pkg::cfg_t  cfg;
        logic             typed;
        csvfs_pkg::kind_t kind;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [csvfs_pkg::ADDR_W-1:0]      paddr;
    logic [31:0]                       pwdata;
    logic [31:0]                       prdata;
    logic                              pready;

    csvfs_in_if  in_ch ();
    csvfs_out_if out_ch ();

    csv_field_splitter DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state and the fields still owed by the block.
    csvfs_pkg::mode_t split_mode;
    csvfs_pkg::cfg_t  split_cfg;
    field_result_t    pending_fields[$];

    logic [7:0] line_buf[$];
    int         send_idle_pct;
    int         recv_idle_pct;
    int         mismatch_count;
    int         cycle_count;

    // Directed lines: plain fields with extremes, quoted field with collapsed
    // and inner quotes ending open, trailing comma, closing quote at the line
    // end, a register write in the middle of a line, and three quotes in a row.
    stim_row_t dir_rows [23] = '{
        '{8'h61,                  1'b0, CFG_BOTH,  1'b1, csvfs_pkg::KIND_BYTE},
        '{csvfs_pkg::QUOTE_CHAR,  1'b0, CFG_BOTH,  1'b1, csvfs_pkg::KIND_BYTE},
        '{csvfs_pkg::COMMA_CHAR,  1'b0, CFG_BOTH,  1'b1, csvfs_pkg::KIND_END},
        '{8'h00,                  1'b0, CFG_BOTH,  1'b1, csvfs_pkg::KIND_BYTE},
        '{8'hFF,                  1'b1, CFG_BOTH,  1'b1, csvfs_pkg::KIND_END},
        '{csvfs_pkg::QUOTE_CHAR,  1'b0, CFG_BOTH,  1'b0, csvfs_pkg::KIND_BYTE},
        '{csvfs_pkg::COMMA_CHAR,  1'b0, CFG_BOTH,  1'b1, csvfs_pkg::KIND_BYTE},
        '{csvfs_pkg::QUOTE_CHAR,  1'b0, CFG_BOTH,  1'b0, csvfs_pkg::KIND_BYTE},
        '{csvfs_pkg::QUOTE_CHAR,  1'b0, CFG_BOTH,  1'b1, csvfs_pkg::KIND_BYTE},
        '{csvfs_pkg::QUOTE_CHAR,  1'b0, CFG_BOTH,  1'b0, csvfs_pkg::KIND_BYTE},
        '{8'h78,                  1'b0, CFG_BOTH,  1'b1, csvfs_pkg::KIND_BYTE},
        '{csvfs_pkg::QUOTE_CHAR,  1'b0, CFG_BOTH,  1'b0, csvfs_pkg::KIND_BYTE},
        '{8'h62,                  1'b1, CFG_BOTH,  1'b1, csvfs_pkg::KIND_ERROR},
        '{csvfs_pkg::COMMA_CHAR,  1'b1, CFG_BOTH,  1'b1, csvfs_pkg::KIND_END},
        '{csvfs_pkg::QUOTE_CHAR,  1'b0, CFG_BOTH,  1'b0, csvfs_pkg::KIND_BYTE},
        '{csvfs_pkg::QUOTE_CHAR,  1'b1, CFG_BOTH,  1'b1, csvfs_pkg::KIND_END},
        '{csvfs_pkg::QUOTE_CHAR,  1'b0, CFG_BOTH,  1'b0, csvfs_pkg::KIND_BYTE},
        '{csvfs_pkg::QUOTE_CHAR,  1'b0, CFG_BOTH,  1'b0, csvfs_pkg::KIND_BYTE},
        '{8'h7A,                  1'b0, CFG_PAIRS, 1'b1, csvfs_pkg::KIND_END},
        '{8'h71,                  1'b1, CFG_PAIRS, 1'b1, csvfs_pkg::KIND_ERROR},
        '{csvfs_pkg::QUOTE_CHAR,  1'b0, CFG_INNER, 1'b0, csvfs_pkg::KIND_BYTE},
        '{csvfs_pkg::QUOTE_CHAR,  1'b0, CFG_INNER, 1'b0, csvfs_pkg::KIND_BYTE},
        '{csvfs_pkg::QUOTE_CHAR,  1'b1, CFG_INNER, 1'b1, csvfs_pkg::KIND_END}
    };

    csvfs_pkg::cfg_t phase_cfg [6] = '{CFG_NONE, CFG_BOTH, CFG_INNER, CFG_PAIRS,
                                       CFG_BOTH, CFG_NONE};

    // Clock with period 4.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Cycle counter with a hard stop.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL csv_field_splitter");
            $finish;
        end
    end

    // The receiver stalls at random according to the current phase.
    always @(posedge clk)
    begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what, input int want, input int got);
        $display("MISMATCH %s: expected %0d, got %0d (cycle %0d)", what, want, got,
                 cycle_count);
        mismatch_count++;
    endtask

    function automatic field_result_t field_out(input csvfs_pkg::kind_t k,
                                                input logic [7:0] b);
        field_result_t r;
        r.kind      = k;
        r.fbyte     = b;
        r.line_done = 1'b0;
        r.run_last  = 1'b0;
        return r;
    endfunction

    // Splitter predictor: advances the parse by one byte, queues the fields it
    // owes, and returns how many there are along with the last one.
    function automatic int split_byte(input logic [7:0] b, input logic last,
                                      output field_result_t last_res);
        field_result_t    step_res[$];
        logic             err;
        csvfs_pkg::mode_t m;
        err = 1'b0;
        m   = split_mode;
        last_res = '0;
        case (m)
            csvfs_pkg::MODE_QSEEN:
            begin
                if (b == csvfs_pkg::QUOTE_CHAR && split_cfg.collapse_quote_pairs)
                begin
                    step_res.push_back(field_out(csvfs_pkg::KIND_BYTE,
                                                 csvfs_pkg::QUOTE_CHAR));
                    m   = csvfs_pkg::MODE_QUOTED;
                    err = last;
                end
                else if (b == csvfs_pkg::COMMA_CHAR)
                begin
                    step_res.push_back(field_out(csvfs_pkg::KIND_END, 8'h00));
                    m = csvfs_pkg::MODE_START;
                    if (last)
                        step_res.push_back(field_out(csvfs_pkg::KIND_END, 8'h00));
                end
                else if (split_cfg.allow_inner_quotes)
                begin
                    // The held quote turns out to be content.
                    step_res.push_back(field_out(csvfs_pkg::KIND_BYTE,
                                                 csvfs_pkg::QUOTE_CHAR));
                    if (b == csvfs_pkg::QUOTE_CHAR)
                    begin
                        m = csvfs_pkg::MODE_QSEEN;
                        if (last)
                            step_res.push_back(field_out(csvfs_pkg::KIND_END, 8'h00));
                    end
                    else
                    begin
                        step_res.push_back(field_out(csvfs_pkg::KIND_BYTE, b));
                        m   = csvfs_pkg::MODE_QUOTED;
                        err = last;
                    end
                end
                else
                begin
                    // Closing quote followed by junk: end the field, skip the rest.
                    step_res.push_back(field_out(csvfs_pkg::KIND_END, 8'h00));
                    m   = csvfs_pkg::MODE_SKIP;
                    err = last;
                end
            end
            csvfs_pkg::MODE_QUOTED:
            begin
                if (b == csvfs_pkg::QUOTE_CHAR)
                begin
                    m = csvfs_pkg::MODE_QSEEN;
                    if (last)
                        step_res.push_back(field_out(csvfs_pkg::KIND_END, 8'h00));
                end
                else
                begin
                    step_res.push_back(field_out(csvfs_pkg::KIND_BYTE, b));
                    err = last;
                end
            end
            csvfs_pkg::MODE_SKIP:
            begin
                err = last;
            end
            default:
            begin
                if (m != csvfs_pkg::MODE_PLAIN && b == csvfs_pkg::QUOTE_CHAR)
                begin
                    m   = csvfs_pkg::MODE_QUOTED;
                    err = last;
                end
                else if (b == csvfs_pkg::COMMA_CHAR)
                begin
                    step_res.push_back(field_out(csvfs_pkg::KIND_END, 8'h00));
                    m = csvfs_pkg::MODE_START;
                    if (last)
                        step_res.push_back(field_out(csvfs_pkg::KIND_END, 8'h00));
                end
                else
                begin
                    step_res.push_back(field_out(csvfs_pkg::KIND_BYTE, b));
                    m = csvfs_pkg::MODE_PLAIN;
                    if (last)
                        step_res.push_back(field_out(csvfs_pkg::KIND_END, 8'h00));
                end
            end
        endcase
        if (err)
            step_res.push_back(field_out(csvfs_pkg::KIND_ERROR, 8'h00));
        split_mode = last ? csvfs_pkg::MODE_START : m;

        // Flag the last field of the byte and of the line.
        foreach (step_res[k])
        begin
            step_res[k].run_last  = (k == step_res.size() - 1);
            step_res[k].line_done = step_res[k].run_last && last;
            pending_fields.push_back(step_res[k]);
            last_res = step_res[k];
        end
        return step_res.size();
    endfunction

    // Check each output transaction against the oldest owed field.
    always @(posedge clk)
    begin
        field_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_fields.size() == 0)
                report_mismatch("unexpected result, kind", -1, out_ch.kind);
            else
            begin
                want = pending_fields.pop_front();
                if (out_ch.kind !== want.kind)
                    report_mismatch("kind", want.kind, out_ch.kind);
                if (out_ch.field_byte !== want.fbyte)
                    report_mismatch("field_byte", want.fbyte, out_ch.field_byte);
                if (out_ch.line_done !== want.line_done)
                    report_mismatch("line_done", want.line_done, out_ch.line_done);
                if (out_ch.run_last !== want.run_last)
                    report_mismatch("run_last", want.run_last, out_ch.run_last);
            end
        end
    end

    // Offers one byte and waits for the transaction; the predictor runs on acceptance.
    task automatic send_byte(input logic [7:0] b, input logic last,
                             output int n, output field_result_t last_res);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.text_byte <= b;
        in_ch.line_end  <= last;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        n = split_byte(b, last, last_res);
    endtask

    // Holds the input until every owed field has come out and the pipe is empty.
    task automatic quiesce();
        in_ch.valid <= 1'b0;
        while (pending_fields.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write followed by a read-back of the same register, then the bus goes idle.
    task automatic apb_write(input logic idx, input logic val);
        logic [31:0] noise;
        noise = $urandom;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {noise[31:1], val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        if (prdata[0] !== val)
            report_mismatch("register read-back", val, prdata[0]);
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_config(input csvfs_pkg::cfg_t cfg);
        apb_write(csvfs_pkg::REG_COLLAPSE, cfg.collapse_quote_pairs);
        apb_write(csvfs_pkg::REG_ALLOW, cfg.allow_inner_quotes);
        split_cfg = cfg;
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        while (c == csvfs_pkg::QUOTE_CHAR || c == csvfs_pkg::COMMA_CHAR)
            c = 8'($urandom_range(255));
        return c;
    endfunction

    // Builds one random line: mostly well-formed plain and quoted fields, some
    // broken quoting and some noise made of quotes, commas and random bytes.
    task automatic build_line();
        int nf;
        int n;
        int style;
        int r;
        line_buf.delete();
        nf = $urandom_range(3, 1);
        for (int f = 0; f < nf; f++)
        begin
            if (f > 0)
                line_buf.push_back(csvfs_pkg::COMMA_CHAR);
            style = $urandom_range(9);
            n     = $urandom_range(4);
            if (style < 4)
            begin
                for (int i = 0; i < n; i++)
                    line_buf.push_back(($urandom_range(9) == 0 && i > 0)
                                       ? csvfs_pkg::QUOTE_CHAR : plain_char());
            end
            else if (style < 9)
            begin
                line_buf.push_back(csvfs_pkg::QUOTE_CHAR);
                for (int i = 0; i < n; i++)
                begin
                    r = $urandom_range(9);
                    if (r == 6)
                        line_buf.push_back(csvfs_pkg::COMMA_CHAR);
                    else if (r == 7)
                    begin
                        line_buf.push_back(csvfs_pkg::QUOTE_CHAR);
                        line_buf.push_back(csvfs_pkg::QUOTE_CHAR);
                    end
                    else if (r == 8)
                        line_buf.push_back(csvfs_pkg::QUOTE_CHAR);
                    else
                        line_buf.push_back(8'($urandom_range(255)));
                end
                r = $urandom_range(9);
                if (r != 0)
                    line_buf.push_back(csvfs_pkg::QUOTE_CHAR);
                if (r == 1)
                    line_buf.push_back(plain_char());
            end
            else
            begin
                for (int i = 0; i <= n; i++)
                begin
                    r = $urandom_range(2);
                    line_buf.push_back(r == 0 ? csvfs_pkg::QUOTE_CHAR :
                                       r == 1 ? csvfs_pkg::COMMA_CHAR :
                                                8'($urandom_range(255)));
                end
            end
        end
        if ($urandom_range(7) == 0)
            line_buf.push_back(csvfs_pkg::COMMA_CHAR);
        if (line_buf.size() == 0)
            line_buf.push_back(8'($urandom_range(255)));
    endtask

    // Main sequence: reset, directed table, random phases, drain and verdict.
    initial
    begin
        int            n;
        int            sent;
        field_result_t last_res;
        stim_row_t     row;

        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.text_byte = 8'h00;
        in_ch.line_end  = 1'b0;
        out_ch.ready    = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        cycle_count     = 0;
        mismatch_count  = 0;
        send_idle_pct   = 19;
        recv_idle_pct   = 57;
        split_mode      = csvfs_pkg::MODE_START;
        split_cfg       = CFG_BOTH;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table; a change of setting is written once the block is idle.
        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.cfg != split_cfg)
            begin
                quiesce();
                write_config(row.cfg);
            end
            send_byte(row.text, row.last, n, last_res);
            if (row.typed && (n == 0 || last_res.kind != row.kind ||
                              last_res.line_done != row.last))
                report_mismatch("directed row kind", row.kind, n == 0 ? -1 : last_res.kind);
        end

        // Random lines over several settings and idling patterns.
        for (int p = 0; p < 6; p++)
        begin
            send_idle_pct = (p < 2) ? 19 : (p < 4) ? 57 : 0;
            recv_idle_pct = (p < 2) ? 57 : (p < 4) ? 19 : 0;
            quiesce();
            write_config(phase_cfg[p]);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                if ($urandom_range(29) == 0)
                    quiesce();
                build_line();
                foreach (line_buf[i])
                    send_byte(line_buf[i], i == line_buf.size() - 1, n, last_res);
                sent += line_buf.size();
            end
        end

        quiesce();
        if (mismatch_count == 0)
            $display("PASS csv_field_splitter");
        else
            $display("FAIL csv_field_splitter");
        $finish;
    end

endmodule
